### src/sfdj_pkg.sv
`timescale 1ns / 1ps

package sfdj_pkg;

    localparam int ENTRIES_DEF  = 4096;
    localparam int POS_BITS_DEF = 33;
    localparam int ACT_W        = 2;

    localparam logic [ACT_W-1:0] ACT_APPEND  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_QUERY   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RESTART = 2'd2;

    typedef struct packed {
        logic append;
        logic restart;
        logic load_pos;
        logic fetch;
        logic eval;
        logic emit_none;
    } sfdj_cmd_t;

    typedef struct packed {
        logic more;
        logic stop;
    } sfdj_status_t;

endpackage

### src/sfdj_ctrl.sv
`timescale 1ns / 1ps

module sfdj_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [sfdj_pkg::ACT_W-1:0] action,
    input  sfdj_pkg::sfdj_status_t     status,
    output sfdj_pkg::sfdj_cmd_t        cmd,
    output logic                       busy
);
    import sfdj_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_EVAL  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       take;

    assign busy = (state_reg != S_IDLE);
    assign take = start && !busy;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    cmd.append   = (action == ACT_APPEND);
                    cmd.restart  = (action == ACT_RESTART);
                    cmd.load_pos = (action == ACT_QUERY);
                    if (action == ACT_QUERY)
                    begin
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                if (status.more)
                begin
                    cmd.fetch  = 1'b1;
                    state_next = S_EVAL;
                end
                else
                begin
                    cmd.emit_none = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = status.stop ? S_IDLE : S_FETCH;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### src/sfdj_datapath.sv
`timescale 1ns / 1ps

module sfdj_datapath #(
    parameter int ENTRIES  = sfdj_pkg::ENTRIES_DEF,
    parameter int POS_BITS = sfdj_pkg::POS_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sfdj_pkg::sfdj_cmd_t    cmd,
    output sfdj_pkg::sfdj_status_t status,
    input  logic [POS_BITS-1:0]    position,
    input  logic [POS_BITS-1:0]    lower_bound,
    input  logic [POS_BITS-1:0]    elem_start,
    input  logic [POS_BITS-1:0]    elem_end,
    input  logic [POS_BITS-1:0]    upper_bound,
    input  logic                   lower_valid,
    input  logic                   upper_valid,
    input  logic                   reverse_strand,
    output logic                   done,
    output logic                   hit,
    output logic signed [POS_BITS:0] distance,
    output logic [POS_BITS-1:0]    length
);
    import sfdj_pkg::*;

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [POS_BITS-1:0] lower_mem [ENTRIES];
    logic [POS_BITS-1:0] start_mem [ENTRIES];
    logic [POS_BITS-1:0] end_mem   [ENTRIES];
    logic [POS_BITS-1:0] upper_mem [ENTRIES];
    logic [2:0]          flag_mem  [ENTRIES];

    logic [POS_BITS-1:0] rd_lower_reg;
    logic [POS_BITS-1:0] rd_start_reg;
    logic [POS_BITS-1:0] rd_end_reg;
    logic [POS_BITS-1:0] rd_upper_reg;
    logic [2:0]          rd_flag_reg;

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [CNT_W-1:0]    ptr_reg;
    logic [CNT_W-1:0]    ptr_next;
    logic                phase_reg;
    logic                phase_next;
    logic [POS_BITS-1:0] pos_reg;

    logic                done_reg;
    logic                hit_reg;
    logic [POS_BITS:0]   dist_reg;
    logic [POS_BITS-1:0] len_reg;

    logic                wr_en;
    logic                lo_take;
    logic                up_take;
    logic                hit_now;
    logic [POS_BITS:0]   pos_x;
    logic [POS_BITS:0]   edge_x;
    logic [POS_BITS:0]   diff;

    assign wr_en       = cmd.append && (count_reg < CNT_W'(ENTRIES));
    assign status.more = (ptr_reg < count_reg);

    assign lo_take     = !phase_reg && rd_flag_reg[0] && (pos_reg < rd_start_reg);
    assign up_take     = rd_flag_reg[1] && (pos_reg < rd_upper_reg);
    assign status.stop = lo_take || up_take;
    assign hit_now     = lo_take ? (pos_reg >= rd_lower_reg) : (pos_reg >= rd_end_reg);

    assign pos_x  = {1'b0, pos_reg};
    assign edge_x = {1'b0, (lo_take ? rd_start_reg : rd_end_reg)};
    assign diff   = rd_flag_reg[2] ? (edge_x - pos_x) : (pos_x - edge_x);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            lower_mem[count_reg[IDX_W-1:0]] <= lower_bound;
            start_mem[count_reg[IDX_W-1:0]] <= elem_start;
            end_mem[count_reg[IDX_W-1:0]]   <= elem_end;
            upper_mem[count_reg[IDX_W-1:0]] <= upper_bound;
            flag_mem[count_reg[IDX_W-1:0]]  <= {reverse_strand, upper_valid, lower_valid};
        end
        if (cmd.fetch)
        begin
            rd_lower_reg <= lower_mem[ptr_reg[IDX_W-1:0]];
            rd_start_reg <= start_mem[ptr_reg[IDX_W-1:0]];
            rd_end_reg   <= end_mem[ptr_reg[IDX_W-1:0]];
            rd_upper_reg <= upper_mem[ptr_reg[IDX_W-1:0]];
            rd_flag_reg  <= flag_mem[ptr_reg[IDX_W-1:0]];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        ptr_next   = ptr_reg;
        phase_next = phase_reg;
        priority if (cmd.restart)
        begin
            count_next = '0;
            ptr_next   = '0;
            phase_next = 1'b0;
        end
        else if (wr_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.eval)
        begin
            if (lo_take)
            begin
                phase_next = 1'b0;
            end
            else if (up_take)
            begin
                phase_next = 1'b1;
            end
            else
            begin
                phase_next = 1'b0;
                ptr_next   = ptr_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ptr_reg   <= '0;
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            phase_reg <= phase_next;
            done_reg  <= cmd.emit_none || (cmd.eval && status.stop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_pos)
        begin
            pos_reg <= position;
        end
        if (cmd.emit_none || (cmd.eval && status.stop && !hit_now))
        begin
            hit_reg  <= 1'b0;
            dist_reg <= '0;
            len_reg  <= '0;
        end
        else if (cmd.eval && status.stop)
        begin
            hit_reg  <= 1'b1;
            dist_reg <= diff;
            len_reg  <= rd_end_reg - rd_start_reg;
        end
    end

    assign done     = done_reg;
    assign hit      = hit_reg;
    assign distance = $signed(dist_reg);
    assign length   = len_reg;

endmodule

### src/sorted_flank_distance_join.sv
`timescale 1ns / 1ps
// Append, restart and idle actions are taken from idle and keep busy low.
// A query alternates a table read and an evaluation of that entry until it stops in a flank
// or runs off the table; the done strobe is registered from that last step.
// The next item can transfer in the cycle the result strobe is shown.
// rst_n clears table count, pointer and phase at once; table contents stay undefined.
// The receiver cannot stall: each result is shown for exactly one cycle.

module sorted_flank_distance_join #(
    parameter int ENTRIES  = sfdj_pkg::ENTRIES_DEF,
    parameter int POS_BITS = sfdj_pkg::POS_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [sfdj_pkg::ACT_W-1:0] action,
    input  logic [POS_BITS-1:0]        position,
    input  logic [POS_BITS-1:0]        lower_bound,
    input  logic [POS_BITS-1:0]        elem_start,
    input  logic [POS_BITS-1:0]        elem_end,
    input  logic [POS_BITS-1:0]        upper_bound,
    input  logic                       lower_valid,
    input  logic                       upper_valid,
    input  logic                       reverse_strand,
    output logic                       done,
    output logic                       hit,
    output logic signed [POS_BITS:0]   distance,
    output logic [POS_BITS-1:0]        length
);
    import sfdj_pkg::*;

    sfdj_cmd_t    cmd;
    sfdj_status_t status;

    sfdj_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    sfdj_datapath #(
        .ENTRIES  (ENTRIES),
        .POS_BITS (POS_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .position       (position),
        .lower_bound    (lower_bound),
        .elem_start     (elem_start),
        .elem_end       (elem_end),
        .upper_bound    (upper_bound),
        .lower_valid    (lower_valid),
        .upper_valid    (upper_valid),
        .reverse_strand (reverse_strand),
        .done           (done),
        .hit            (hit),
        .distance       (distance),
        .length         (length)
    );

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import sfdj_pkg::*;

    localparam int                TAB_DEPTH = ENTRIES_DEF;
    localparam logic [ACT_W-1:0]  ACT_NOP   = 2'd3;
    localparam logic [32:0]       POS_MAX   = 33'h1_FFFF_FFFF;
    localparam int                RANDOM_ITEMS = 1250;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic [32:0]      pos;
        logic [32:0]      lo;
        logic [32:0]      st;
        logic [32:0]      en;
        logic [32:0]      up;
        logic             lv;
        logic             uv;
        logic             rev;
        logic [6:0]       idle_pct;
    } cmd_item_t;

    typedef struct packed {
        logic [32:0] lo;
        logic [32:0] st;
        logic [32:0] en;
        logic [32:0] up;
        logic        lv;
        logic        uv;
        logic        rev;
    } flank_entry_t;

    typedef struct packed {
        logic        hit;
        logic [33:0] distance;
        logic [32:0] length;
    } flank_result_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [ACT_W-1:0]   action = '0;
    logic [32:0]        position = '0;
    logic [32:0]        lower_bound = '0;
    logic [32:0]        elem_start = '0;
    logic [32:0]        elem_end = '0;
    logic [32:0]        upper_bound = '0;
    logic               lower_valid = 1'b0;
    logic               upper_valid = 1'b0;
    logic               reverse_strand = 1'b0;
    logic               done;
    logic               hit;
    logic signed [33:0] distance;
    logic [32:0]        length;

    cmd_item_t     cmd_queue[$];
    flank_result_t expected_joins[$];
    flank_entry_t  flank_tab[TAB_DEPTH];
    int unsigned   entry_total = 0;
    int unsigned   walk_idx = 0;
    bit            walk_upper = 1'b0;
    bit            offer_taken = 1'b0;
    int            error_count = 0;
    int            random_count = 0;
    int            query_count = 0;
    int            hit_count = 0;
    int            append_count = 0;
    int            restart_count = 0;
    logic [63:0]   cursor;

    sorted_flank_distance_join dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .action         (action),
        .position       (position),
        .lower_bound    (lower_bound),
        .elem_start     (elem_start),
        .elem_end       (elem_end),
        .upper_bound    (upper_bound),
        .lower_valid    (lower_valid),
        .upper_valid    (upper_valid),
        .reverse_strand (reverse_strand),
        .done           (done),
        .hit            (hit),
        .distance       (distance),
        .length         (length)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (error_count < 40)
            $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        error_count++;
    endtask

    function automatic flank_result_t flank_hit(input logic [32:0] pos,
                                                input logic [32:0] edge_pos,
                                                input flank_entry_t e);
        flank_result_t r;
        r.hit      = 1'b1;
        r.distance = {1'b0, pos} - {1'b0, edge_pos};
        if (e.rev)
            r.distance = -r.distance;
        r.length   = e.en - e.st;
        return r;
    endfunction

    // advance the pointer and phase; stop at the first active flank
    function automatic void predict_query(input logic [32:0] pos);
        flank_result_t r;
        flank_entry_t  e;
        bit            stopped;
        r       = '0;
        stopped = 1'b0;
        while (!stopped && walk_idx < entry_total) begin
            e = flank_tab[walk_idx];
            if (!walk_upper) begin
                if (e.lv && pos < e.st) begin
                    stopped = 1'b1;
                    if (pos >= e.lo)
                        r = flank_hit(pos, e.st, e);
                end
                else
                    walk_upper = 1'b1;
            end
            else begin
                if (e.uv && pos < e.up) begin
                    stopped = 1'b1;
                    if (pos >= e.en)
                        r = flank_hit(pos, e.en, e);
                end
                else begin
                    walk_upper = 1'b0;
                    walk_idx++;
                end
            end
        end
        expected_joins.push_back(r);
    endfunction

    function automatic void apply_transfer();
        flank_entry_t e;
        case (action)
            ACT_APPEND:
            begin
                append_count++;
                if (entry_total < TAB_DEPTH) begin
                    e = '{lower_bound, elem_start, elem_end, upper_bound,
                          lower_valid, upper_valid, reverse_strand};
                    flank_tab[entry_total] = e;
                    entry_total++;
                end
            end
            ACT_QUERY:
            begin
                query_count++;
                predict_query(position);
            end
            ACT_RESTART:
            begin
                restart_count++;
                entry_total = 0;
                walk_idx    = 0;
                walk_upper  = 1'b0;
            end
            default: ;
        endcase
    endfunction

    always @(posedge clk)
    begin
        flank_result_t want;
        if (rst_n) begin
            if (done) begin
                if (expected_joins.size() == 0)
                    report_mismatch("result with none pending", 64'(hit), '0);
                else begin
                    want = expected_joins.pop_front();
                    if (hit)
                        hit_count++;
                    if (hit !== want.hit)
                        report_mismatch("hit", 64'(hit), 64'(want.hit));
                    if (distance !== want.distance)
                        report_mismatch("distance", 64'($unsigned(distance)),
                                        64'(want.distance));
                    if (length !== want.length)
                        report_mismatch("length", 64'(length), 64'(want.length));
                end
            end
            if (start && !busy) begin
                offer_taken = 1'b1;
                apply_transfer();
            end
        end
    end

    always @(negedge clk)
    begin
        bit        taken;
        cmd_item_t c;
        taken = offer_taken;
        offer_taken = 1'b0;
        if (taken)
            void'(cmd_queue.pop_front());
        if (!rst_n)
            start <= 1'b0;
        else if (start && !taken) begin
            // hold the offer until it transfers
        end
        else if (cmd_queue.size() != 0 && $urandom_range(99) >= cmd_queue[0].idle_pct) begin
            c = cmd_queue[0];
            start          <= 1'b1;
            action         <= c.act;
            position       <= c.pos;
            lower_bound    <= c.lo;
            elem_start     <= c.st;
            elem_end       <= c.en;
            upper_bound    <= c.up;
            lower_valid    <= c.lv;
            upper_valid    <= c.uv;
            reverse_strand <= c.rev;
        end
        else
            start <= 1'b0;
    end

    function automatic logic [32:0] rand33();
        logic [32:0] v;
        v     = {1'b0, $urandom()};
        v[32] = 1'($urandom_range(1));
        return v;
    endfunction

    function automatic logic [63:0] rand_gap();
        if ($urandom_range(3) == 0)
            return 64'($urandom_range(1 << 20));
        return 64'($urandom_range(40));
    endfunction

    task automatic push_item(input logic [ACT_W-1:0] act, input logic [32:0] pos,
                             input logic [32:0] lo, input logic [32:0] st,
                             input logic [32:0] en, input logic [32:0] up,
                             input logic lv, input logic uv, input logic rev,
                             input int idle_pct);
        cmd_item_t c;
        c = '{act, pos, lo, st, en, up, lv, uv, rev, idle_pct[6:0]};
        cmd_queue.push_back(c);
    endtask

    task automatic push_query(input logic [32:0] pos, input int idle_pct);
        push_item(ACT_QUERY, pos, rand33(), rand33(), rand33(), rand33(),
                  1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  idle_pct);
    endtask

    task automatic push_sorted_entry(input int idle_pct);
        logic [63:0] lo;
        logic [63:0] st;
        logic [63:0] en;
        logic [63:0] up;
        lo = cursor + rand_gap();
        st = lo + rand_gap();
        en = st + rand_gap();
        up = en + rand_gap();
        if ($urandom_range(15) == 0)
            en = st - 64'($urandom_range(1, 30));
        cursor = up + 64'($urandom_range(8));
        push_item(ACT_APPEND, rand33(), lo[32:0], st[32:0], en[32:0], up[32:0],
                  $urandom_range(3) != 0, $urandom_range(3) != 0, 1'($urandom_range(1)),
                  idle_pct);
        random_count++;
    endtask

    task automatic push_join_run(input int idle_pct);
        logic [63:0] base;
        logic [63:0] pos;
        int          n_ent;
        int          n_qry;
        logic [63:0] step;
        base   = ($urandom_range(7) == 0) ? 64'(POS_MAX) - 64'($urandom_range(1 << 22))
                                          : 64'(rand33());
        cursor = base;
        n_ent  = $urandom_range(1, 12);
        n_qry  = $urandom_range(1, 16);
        push_item(ACT_RESTART, rand33(), rand33(), rand33(), rand33(), rand33(),
                  1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  idle_pct);
        random_count++;
        for (int i = 0; i < n_ent; i++)
            push_sorted_entry(idle_pct);
        step = (cursor - base) / 64'(n_qry) + 64'd2;
        pos  = base;
        for (int i = 0; i < n_qry; i++) begin
            pos = pos + (($urandom_range(5) == 0) ? 64'($urandom_range(3))
                                                  : step * 64'($urandom_range(200)) / 64'd100);
            if ($urandom_range(19) == 0)
                push_sorted_entry(idle_pct);
            push_query(pos[32:0], idle_pct);
            random_count++;
        end
    endtask

    task automatic push_noise(input int idle_pct);
        logic [ACT_W-1:0] act;
        int               n;
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
            act = ACT_W'($urandom_range(3));
            push_item(act, rand33(), rand33(), rand33(), rand33(), rand33(),
                      1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                      idle_pct);
            if (act != ACT_NOP)
                random_count++;
        end
    endtask

    task automatic push_directed();
        push_query(33'd5, 0);
        push_item(ACT_NOP, POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX,
                  1'b1, 1'b1, 1'b1, 0);
        push_item(ACT_RESTART, '0, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0, 0);
        push_item(ACT_APPEND, '0, 33'd0, 33'd10, 33'd20, 33'd30, 1'b1, 1'b1, 1'b0, 0);
        push_item(ACT_APPEND, '0, 33'd100, 33'd120, 33'd110, 33'd140, 1'b1, 1'b1, 1'b1, 0);
        push_item(ACT_APPEND, '0, POS_MAX - 33'd40, POS_MAX - 33'd20, POS_MAX - 33'd10,
                  POS_MAX, 1'b1, 1'b1, 1'b1, 0);
        push_query(33'd0, 0);
        push_query(33'd9, 0);
        push_query(33'd10, 0);
        push_query(33'd25, 0);
        push_query(33'd30, 0);
        push_query(33'd5, 0);
        push_query(33'd105, 0);
        push_query(33'd115, 0);
        push_item(ACT_APPEND, POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX,
                  1'b0, 1'b0, 1'b0, 0);
        push_query(POS_MAX - 33'd30, 0);
        push_query(POS_MAX - 33'd1, 0);
        push_query(POS_MAX, 0);
        push_query(33'd0, 0);
        push_item(ACT_RESTART, '0, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0, 0);
        push_item(ACT_APPEND, '0, 33'd50, 33'd60, 33'd70, 33'd90, 1'b0, 1'b1, 1'b1, 0);
        push_query(33'd55, 0);
        push_query(33'd80, 0);
    endtask

    initial
    begin
        int phase_pct[4];
        int pct;
        phase_pct = '{0, 85, 0, 27};
        push_directed();
        while (random_count < RANDOM_ITEMS) begin
            pct = phase_pct[(random_count * 4) / RANDOM_ITEMS];
            if ($urandom_range(99) < 80)
                push_join_run(pct);
            else
                push_noise(pct);
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (cmd_queue.size() != 0 || start || expected_joins.size() != 0);
        repeat (20) @(posedge clk);

        while (expected_joins.size() != 0) begin
            void'(expected_joins.pop_front());
            report_mismatch("result never arrived", '0, '0);
        end

        $display("covered %0d queries (%0d hits), %0d appends, %0d restarts,",
                 query_count, hit_count, append_count, restart_count);
        $display("with sender gaps of 0/85/27 percent and appends mixed into query streams");
        if (error_count == 0)
            $display("[sorted_flank_distance_join] OK");
        else
            $display("[sorted_flank_distance_join] ERROR");
        $finish;
    end

    initial
    begin
        #16_000_000;
        $display("timeout at %0t", $time);
        $display("[sorted_flank_distance_join] ERROR");
        $finish;
    end

endmodule
